// ===== design/tle_pkg.sv =====
// Shared types, key codes and the microprogram of the terminal line editor.
// Used by tle_seq and terminal_line_editor; depends on nothing else.
`default_nettype none

package tle_pkg;

   localparam int TLE_LINE_WIDTH = 40;
   localparam int KEY_W          = 8;
   localparam int CHAR_W         = 7;
   localparam int STEP_W         = 5;

   localparam logic [KEY_W-1:0]  KEY_LF     = 8'h0A;
   localparam logic [KEY_W-1:0]  KEY_CR     = 8'h0D;
   localparam logic [KEY_W-1:0]  KEY_EOF    = 8'h04;
   localparam logic [KEY_W-1:0]  KEY_KILL   = 8'h15;
   localparam logic [KEY_W-1:0]  KEY_WERASE = 8'h17;
   localparam logic [KEY_W-1:0]  KEY_DEL    = 8'h7F;
   localparam logic [KEY_W-1:0]  PRINT_LOW  = 8'h20;
   localparam logic [KEY_W-1:0]  PRINT_HIGH = 8'h7E;
   localparam logic [CHAR_W-1:0] CHAR_SPACE = 7'h20;

   typedef logic [STEP_W-1:0] tle_step_type;

   // Entry points and loop heads of the microprogram.
   localparam tle_step_type STEP_IDLE     = 5'd0;
   localparam tle_step_type STEP_NEWLINE  = 5'd1;
   localparam tle_step_type STEP_EOF      = 5'd2;
   localparam tle_step_type STEP_DEL      = 5'd3;
   localparam tle_step_type STEP_DEL_DROP = 5'd4;
   localparam tle_step_type STEP_KILL     = 5'd5;
   localparam tle_step_type STEP_KILL_DROP= 5'd6;
   localparam tle_step_type STEP_WERASE   = 5'd7;
   localparam tle_step_type STEP_WE_TEST  = 5'd8;
   localparam tle_step_type STEP_WE_SPACE = 5'd9;
   localparam tle_step_type STEP_WE_DEC   = 5'd10;
   localparam tle_step_type STEP_WE_READ  = 5'd11;
   localparam tle_step_type STEP_WE_WORD  = 5'd12;
   localparam tle_step_type STEP_PRINT    = 5'd13;
   localparam tle_step_type STEP_WRAP     = 5'd14;
   localparam tle_step_type STEP_STORE    = 5'd15;
   localparam tle_step_type STEP_BELL     = 5'd16;

   typedef enum logic [1:0] {
      ACT_ECHO  = 2'd0,
      ACT_ERASE = 2'd1,
      ACT_BELL  = 2'd2,
      ACT_END   = 2'd3
   } tle_act_type;

   typedef enum logic [1:0] {
      BSEL_ZERO,
      BSEL_KEY,
      BSEL_LF
   } tle_bsel_type;

   typedef enum logic [1:0] {
      LAST_ZERO,
      LAST_ONE,
      LAST_COND
   } tle_last_type;

   typedef enum logic [1:0] {
      LEN_HOLD,
      LEN_CLEAR,
      LEN_DEC,
      LEN_INC
   } tle_lenop_type;

   typedef enum logic [2:0] {
      COND_ALWAYS,
      COND_LEN_ZERO,
      COND_LEN_ONE,
      COND_NOT_SPACE,
      COND_LEN_FULL,
      COND_STOP_WORD
   } tle_cond_type;

   // One control word of the microprogram.
   typedef struct packed {
      logic          dispatch;
      logic          emit;
      tle_act_type   act;
      tle_bsel_type  bsel;
      tle_last_type  lsel;
      tle_lenop_type lop;
      logic          wr;
      logic          set_done;
      tle_cond_type  cond;
      tle_step_type  tgt_t;
      tle_step_type  tgt_f;
   } tle_uop_type;

   // Status from the datapath to the sequencer.
   typedef struct packed {
      logic         start;
      tle_step_type entry;
      logic         out_free;
      logic         len_zero;
      logic         len_one;
      logic         len_full;
      logic         not_space;
      logic         stop_word;
   } tle_flags_type;

   // Control from the sequencer to the datapath.
   typedef struct packed {
      tle_uop_type uop;
      logic        cond_val;
      logic        fire;
      logic        idle;
   } tle_ctl_type;

   // Chooses the routine that handles a newly accepted key.
   function automatic tle_step_type tle_entry(input logic [KEY_W-1:0] key,
                                              input logic len_zero);
      tle_step_type step;
      if (key == KEY_LF || key == KEY_CR)
         step = STEP_NEWLINE;
      else if (key == KEY_EOF && len_zero)
         step = STEP_EOF;
      else if (key == KEY_DEL)
         step = STEP_DEL;
      else if (key == KEY_KILL)
         step = STEP_KILL;
      else if (key == KEY_WERASE)
         step = STEP_WERASE;
      else if (key inside {[PRINT_LOW:PRINT_HIGH]})
         step = STEP_PRINT;
      else
         step = STEP_BELL;
      return step;
   endfunction

   // The microprogram. Each erase step emits one result; the word erase
   // reads the character below the top of the line before deciding.
   function automatic tle_uop_type tle_uop_rom(input tle_step_type step);
      tle_uop_type u;
      u.dispatch = 1'b0;
      u.emit     = 1'b0;
      u.act      = ACT_ECHO;
      u.bsel     = BSEL_ZERO;
      u.lsel     = LAST_ZERO;
      u.lop      = LEN_HOLD;
      u.wr       = 1'b0;
      u.set_done = 1'b0;
      u.cond     = COND_ALWAYS;
      u.tgt_t    = STEP_IDLE;
      u.tgt_f    = STEP_IDLE;
      case (step)
         STEP_IDLE: begin
            u.dispatch = 1'b1;
         end
         STEP_NEWLINE: begin
            u.emit = 1'b1;
            u.bsel = BSEL_KEY;
            u.lsel = LAST_ONE;
            u.lop  = LEN_CLEAR;
         end
         STEP_EOF: begin
            u.emit     = 1'b1;
            u.act      = ACT_END;
            u.lsel     = LAST_ONE;
            u.set_done = 1'b1;
         end
         STEP_DEL: begin
            u.cond  = COND_LEN_ZERO;
            u.tgt_f = STEP_DEL_DROP;
         end
         STEP_DEL_DROP: begin
            u.emit = 1'b1;
            u.act  = ACT_ERASE;
            u.lsel = LAST_ONE;
            u.lop  = LEN_DEC;
         end
         STEP_KILL: begin
            u.cond  = COND_LEN_ZERO;
            u.tgt_f = STEP_KILL_DROP;
         end
         STEP_KILL_DROP: begin
            u.emit  = 1'b1;
            u.act   = ACT_ERASE;
            u.lsel  = LAST_COND;
            u.lop   = LEN_DEC;
            u.cond  = COND_LEN_ONE;
            u.tgt_f = STEP_KILL_DROP;
         end
         STEP_WERASE: begin
            u.cond  = COND_LEN_ZERO;
            u.tgt_f = STEP_WE_TEST;
         end
         STEP_WE_TEST: begin
            u.cond  = COND_NOT_SPACE;
            u.tgt_t = STEP_WE_DEC;
            u.tgt_f = STEP_WE_SPACE;
         end
         STEP_WE_SPACE: begin
            // Whatever lies below a trailing space is also erased.
            u.emit  = 1'b1;
            u.act   = ACT_ERASE;
            u.lsel  = LAST_COND;
            u.lop   = LEN_DEC;
            u.cond  = COND_LEN_ONE;
            u.tgt_f = STEP_WERASE;
         end
         STEP_WE_DEC: begin
            u.lop   = LEN_DEC;
            u.tgt_t = STEP_WE_READ;
            u.tgt_f = STEP_WE_READ;
         end
         STEP_WE_READ: begin
            u.tgt_t = STEP_WE_WORD;
            u.tgt_f = STEP_WE_WORD;
         end
         STEP_WE_WORD: begin
            // The character was already dropped; report it now that the
            // next one down is known.
            u.emit  = 1'b1;
            u.act   = ACT_ERASE;
            u.lsel  = LAST_COND;
            u.cond  = COND_STOP_WORD;
            u.tgt_f = STEP_WE_DEC;
         end
         STEP_PRINT: begin
            u.cond  = COND_LEN_FULL;
            u.tgt_t = STEP_WRAP;
            u.tgt_f = STEP_STORE;
         end
         STEP_WRAP: begin
            u.emit  = 1'b1;
            u.bsel  = BSEL_LF;
            u.lop   = LEN_CLEAR;
            u.tgt_t = STEP_STORE;
            u.tgt_f = STEP_STORE;
         end
         STEP_STORE: begin
            u.emit = 1'b1;
            u.bsel = BSEL_KEY;
            u.lsel = LAST_ONE;
            u.lop  = LEN_INC;
            u.wr   = 1'b1;
         end
         STEP_BELL: begin
            u.emit = 1'b1;
            u.act  = ACT_BELL;
            u.lsel = LAST_ONE;
         end
         default: begin
            u.tgt_t = STEP_IDLE;
         end
      endcase
      return u;
   endfunction

endpackage

`default_nettype wire

// ===== design/tle_ram.sv =====
// Generic single-write, single-read memory with registered read data.
// Stand-alone; used for the line store of the terminal line editor.
`default_nettype none

module tle_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== design/tle_seq.sv =====
// Microcode sequencer: step counter, program table and conditional jumps.
// Depends on tle_pkg for the control word and the program.
`default_nettype none

module tle_seq
   import tle_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire tle_flags_type flags,
   output tle_ctl_type        ctl
);

   tle_step_type step_ff;
   tle_step_type step_in;
   tle_uop_type  uop;
   logic         cond_val;
   logic         fire;

   assign uop = tle_uop_rom(step_ff);

   always_comb begin
      case (uop.cond)
         COND_ALWAYS:    cond_val = 1'b1;
         COND_LEN_ZERO:  cond_val = flags.len_zero;
         COND_LEN_ONE:   cond_val = flags.len_one;
         COND_NOT_SPACE: cond_val = flags.not_space;
         COND_LEN_FULL:  cond_val = flags.len_full;
         COND_STOP_WORD: cond_val = flags.stop_word;
         default:        cond_val = 1'b1;
      endcase
   end

   // A step that emits waits until the output register can take the result.
   assign fire = !(uop.emit && !flags.out_free);

   always_comb begin
      if (uop.dispatch) begin
         step_in = flags.start ? flags.entry : STEP_IDLE;
      end else if (fire) begin
         step_in = cond_val ? uop.tgt_t : uop.tgt_f;
      end else begin
         step_in = step_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= STEP_IDLE;
      end else begin
         step_ff <= step_in;
      end
   end

   assign ctl.uop      = uop;
   assign ctl.cond_val = cond_val;
   assign ctl.fire     = fire && !uop.dispatch;
   assign ctl.idle     = (step_ff == STEP_IDLE);

endmodule

`default_nettype wire

// ===== design/terminal_line_editor.sv =====
//  Channel   Ports                                          Direction
//  request   req_valid, req_stall, req_key_byte            in (stall out)
//  result    rsp_valid, rsp_stall, rsp_action,             out (stall in)
//            rsp_echo_byte, rsp_last
//
// From idle the microprogram runs a step a cycle; a step that emits waits while a result
// is stalled. Newline, EOF and bell run their own step; a printable byte runs PRINT, WRAP
// on a full line, then STORE; DEL runs DEL, then DEL_DROP unless the line is empty; Ctrl-U
// runs KILL, then KILL_DROP per erased character; Ctrl-W erases trailing spaces, then runs
// WE_DEC, WE_READ (for the registered read of the line store) and WE_WORD per character.
// Reset clears the line length, the end-of-session flag, the sequencer and rsp_valid.
// A new request is taken once the sequencer is at idle, even with the last result waiting.
// Depends on tle_pkg, tle_seq and tle_ram.
`default_nettype none

module terminal_line_editor
   import tle_pkg::*;
#(
   parameter int LINE_WIDTH = TLE_LINE_WIDTH
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire logic [KEY_W-1:0] req_key_byte,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output logic      [1:0]       rsp_action,
   output logic      [KEY_W-1:0] rsp_echo_byte,
   output logic                  rsp_last
);

   localparam int LEN_W = $clog2(LINE_WIDTH + 1);
   localparam int AW    = (LINE_WIDTH > 1) ? $clog2(LINE_WIDTH) : 1;

   tle_flags_type     flags;
   tle_ctl_type       ctl;
   logic              accept;
   logic              load_out;
   logic [KEY_W-1:0]  key_ff;
   logic [LEN_W-1:0]  len_ff;
   logic [LEN_W-1:0]  len_in;
   logic              done_ff;
   logic              done_in;
   logic              rsp_valid_ff;
   logic              rsp_valid_in;
   logic [1:0]        action_ff;
   logic [KEY_W-1:0]  byte_ff;
   logic [KEY_W-1:0]  byte_in;
   logic              last_ff;
   logic              last_in;
   logic [AW-1:0]     rd_addr;
   logic [CHAR_W-1:0] rd_data;
   logic              len_zero;

   assign req_stall = !ctl.idle;
   assign accept    = req_valid && !req_stall;
   assign len_zero  = (len_ff == '0);

   // The read port looks at the top character of the line, or address 0 when it is empty.
   assign rd_addr = len_zero ? '0 : AW'(len_ff - LEN_W'(1));

   tle_ram #(
      .WIDTH (CHAR_W),
      .DEPTH (LINE_WIDTH)
   ) u_line_store (
      .clock   (clock),
      .wr_en   (ctl.fire && ctl.uop.wr),
      .wr_addr (len_ff[AW-1:0]),
      .wr_data (key_ff[CHAR_W-1:0]),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      flags.start     = accept;
      flags.entry     = done_ff ? STEP_IDLE : tle_entry(req_key_byte, len_zero);
      flags.out_free  = !rsp_valid_ff || !rsp_stall;
      flags.len_zero  = len_zero;
      flags.len_one   = (len_ff == LEN_W'(1));
      flags.len_full  = (len_ff >= LEN_W'(LINE_WIDTH));
      flags.not_space = (rd_data != CHAR_SPACE);
      flags.stop_word = len_zero || (rd_data == CHAR_SPACE);
   end

   tle_seq u_seq (
      .clock (clock),
      .reset (reset),
      .flags (flags),
      .ctl   (ctl)
   );

   assign load_out = ctl.fire && ctl.uop.emit;

   always_comb begin
      len_in = len_ff;
      if (ctl.fire) begin
         case (ctl.uop.lop)
            LEN_CLEAR: len_in = '0;
            LEN_DEC:   len_in = len_ff - LEN_W'(1);
            LEN_INC:   len_in = len_ff + LEN_W'(1);
            default:   len_in = len_ff;
         endcase
      end
   end

   assign done_in = done_ff || (ctl.fire && ctl.uop.set_done);

   always_comb begin
      case (ctl.uop.bsel)
         BSEL_KEY: byte_in = key_ff;
         BSEL_LF:  byte_in = KEY_LF;
         default:  byte_in = '0;
      endcase
      case (ctl.uop.lsel)
         LAST_ONE:  last_in = 1'b1;
         LAST_COND: last_in = ctl.cond_val;
         default:   last_in = 1'b0;
      endcase
   end

   assign rsp_valid_in = load_out || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff       <= '0;
         done_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         len_ff       <= len_in;
         done_ff      <= done_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         key_ff <= req_key_byte;
      end
      if (load_out) begin
         action_ff <= ctl.uop.act;
         byte_ff   <= byte_in;
         last_ff   <= last_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_action    = action_ff;
   assign rsp_echo_byte = byte_ff;
   assign rsp_last      = last_ff;

`ifndef ASSERT_OFF
   a_no_result_after_end: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !load_out)
      else $error("result produced after end of session");

   a_last_returns_idle: assert property (@(posedge clock) disable iff (reset)
      (load_out && last_in) |=> ctl.idle)
      else $error("sequencer still busy after the final result of a request");

   a_store_in_range: assert property (@(posedge clock) disable iff (reset)
      (ctl.fire && ctl.uop.wr) |-> (len_ff < LEN_W'(LINE_WIDTH)))
      else $error("line store written beyond the line width");

   a_erase_needs_char: assert property (@(posedge clock) disable iff (reset)
      (ctl.fire && ctl.uop.lop == LEN_DEC) |-> !len_zero)
      else $error("erase step on an empty line");
`endif

endmodule

`default_nettype wire
